>>> rtl/core/gwp_pkg.sv
// Shared types, character codes and fixed-point constants of the G-code word parser.
`timescale 1ns / 1ps

package gwp_pkg;

   // Number format: fraction digits kept and the largest mantissa digit count.
   localparam int DECIMALS   = 3;
   localparam int MAX_DIGITS = 9;

   localparam int FRAC_W  = 3;
   localparam int MANT_W  = 32;
   localparam int SCALE_W = 20;
   localparam int PROD_W  = MANT_W + SCALE_W;
   localparam int LIM_W   = 33;

   // Powers of ten used to derive the mantissa limit.
   localparam logic [33:0] POW10_TAB [0:9] = '{
      34'd1, 34'd10, 34'd100, 34'd1000, 34'd10000, 34'd100000, 34'd1000000,
      34'd10000000, 34'd100000000, 34'd1000000000
   };

   localparam logic [MANT_W-1:0] MANT_MAX = MANT_W'(POW10_TAB[MAX_DIGITS] - 34'd1);

   // Scale factor from the mantissa to thousandths, indexed by missing fraction digits.
   localparam logic [SCALE_W-1:0] SCALE_TAB [0:7] = '{
      20'd1, 20'd10, 20'd100, 20'd1000, 20'd10000, 20'd100000, 20'd1000000, 20'd0
   };

   localparam logic [23:0] LINE_MAX  = 24'hFF_FFFF;
   localparam logic [15:0] GCODE_MAX = 16'hFFFF;

   localparam logic [LIM_W-1:0] POS_LIMIT = 33'h0_7FFF_FFFF;
   localparam logic [LIM_W-1:0] NEG_LIMIT = 33'h0_8000_0000;

   // Character codes.
   localparam logic [7:0] NO_LETTER = 8'd0;
   localparam logic [7:0] CH_LF     = 8'd10;
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_POINT  = 8'h2E;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_A      = 8'h41;
   localparam logic [7:0] CH_G      = 8'h47;
   localparam logic [7:0] CH_N      = 8'h4E;
   localparam logic [7:0] CH_X      = 8'h58;
   localparam logic [7:0] CH_Y      = 8'h59;
   localparam logic [7:0] CH_Z      = 8'h5A;

   // Kinds of record the parser emits.
   typedef enum logic [2:0] {
      EV_LINE       = 3'd0,
      EV_COMMAND    = 3'd1,
      EV_X          = 3'd2,
      EV_Y          = 3'd3,
      EV_Z          = 3'd4,
      EV_UNKNOWN    = 3'd5,
      EV_NO_COMMAND = 3'd6,
      EV_EMPTY      = 3'd7
   } event_kind_type;

   // One input request as held in the input register.
   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_item_type;

   // One result record.
   typedef struct packed {
      event_kind_type     event_kind;
      logic [7:0]         word_letter;
      logic [15:0]        gcode_number;
      logic [23:0]        line_number;
      logic signed [31:0] x_thou;
      logic signed [31:0] y_thou;
      logic signed [31:0] z_thou;
   } record_type;

   // Handshake between the parse core and the two register stages.
   typedef struct packed {
      logic produce;
      logic advance;
   } pipe_ctrl_type;

endpackage

>>> rtl/core/gcode_word_parser_unit.sv
// Top level of the G-code word parser: input register, parse core and result register.
`timescale 1ns / 1ps

// Usage:
// The req_ channel takes one ASCII character per request (req_char_code), or an
// end-of-text marker (req_end_of_text) that flushes the pending word. A request is
// taken at a clock edge with req_valid high and req_stall low. Each evaluated word
// gives one record on the rsp_ channel, taken at an edge with rsp_valid high and
// rsp_stall low; characters that only build a word give no record.
// The csr_ channel writes absolute_mode (csr_valid with csr_ready, always ready);
// write it only while the block is idle.
// A request is held in the input register, the parse core evaluates it in a single
// pass, and the record shows in the result register. Throughput is one request per
// cycle unless a record waits on a stalled receiver; the critical path is one 32x20
// scale multiply and clamp feeding the command state and the result register.
// When the receiver stalls with a record waiting, requests that give no record keep
// flowing; a request that would give a record waits in the input register.
// Reset empties both registers, clears all parser state and sets absolute_mode to 1.
module gcode_word_parser_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_code,
   input  logic               req_end_of_text,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_event_kind,
   output logic [7:0]         rsp_word_letter,
   output logic [15:0]        rsp_gcode_number,
   output logic [23:0]        rsp_line_number,
   output logic signed [31:0] rsp_x_thou,
   output logic signed [31:0] rsp_y_thou,
   output logic signed [31:0] rsp_z_thou,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_absolute_mode
);

   logic                   absolute_mode_ff;
   logic                   absolute_mode_in;
   logic                   item_valid;
   gwp_pkg::req_item_type  item;
   logic                   produce;
   logic                   advance;
   logic                   can_take;
   gwp_pkg::record_type    record;
   gwp_pkg::record_type    rsp_record;
   gwp_pkg::pipe_ctrl_type ctrl;

   // Configuration register.
   assign csr_ready        = 1'b1;
   assign absolute_mode_in = (csr_valid && csr_ready) ? csr_absolute_mode : absolute_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         absolute_mode_ff <= 1'b1;
      end else begin
         absolute_mode_ff <= absolute_mode_in;
      end
   end

   // The held request moves on unless it makes a record that has nowhere to go.
   assign advance      = item_valid && (!produce || can_take);
   assign ctrl.produce = produce;
   assign ctrl.advance = advance;

   gwp_req_stage u_req_stage (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .req_end_of_text (req_end_of_text),
      .advance         (advance),
      .item_valid      (item_valid),
      .item            (item)
   );

   gwp_parse_core u_parse_core (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item          (item),
      .advance       (advance),
      .absolute_mode (absolute_mode_ff),
      .produce       (produce),
      .record        (record)
   );

   gwp_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .record     (record),
      .can_take   (can_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_record (rsp_record)
   );

   // Result fields.
   assign rsp_event_kind   = rsp_record.event_kind;
   assign rsp_word_letter  = rsp_record.word_letter;
   assign rsp_gcode_number = rsp_record.gcode_number;
   assign rsp_line_number  = rsp_record.line_number;
   assign rsp_x_thou       = rsp_record.x_thou;
   assign rsp_y_thou       = rsp_record.y_thou;
   assign rsp_z_thou       = rsp_record.z_thou;

   // The input side only stalls while a request is held.
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item_valid)
      else $error("Request stalled with an empty input register.");

   // A record is never loaded over one that the receiver is still stalling.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (produce && advance) |-> (!rsp_valid || !rsp_stall))
      else $error("Result register overwritten while stalled.");

   // A stalled request that makes no record cannot stay stuck.
   a_quiet_item_moves: assert property (@(posedge clock) disable iff (reset)
      (item_valid && !produce) |-> advance)
      else $error("Request without a record failed to advance.");

   // A configuration write lands in the mode register.
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> (absolute_mode_ff == $past(csr_absolute_mode)))
      else $error("Configuration write not taken.");

endmodule

>>> rtl/core/gwp_req_stage.sv
// Input register of the G-code word parser, holding one request until the core takes it.
`timescale 1ns / 1ps

module gwp_req_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_char_code,
   input  logic                  req_end_of_text,
   input  logic                  advance,
   output logic                  item_valid,
   output gwp_pkg::req_item_type item
);

   logic                  valid_ff;
   logic                  valid_in;
   logic                  load;
   gwp_pkg::req_item_type item_ff;

   // Stall only while a held request cannot move on this cycle.
   assign req_stall = valid_ff && !advance;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload capture needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.char_code   <= req_char_code;
         item_ff.end_of_text <= req_end_of_text;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> rtl/core/gwp_parse_core.sv
// Tokenizer state and single-pass word evaluation of the G-code word parser.
`timescale 1ns / 1ps

module gwp_parse_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  gwp_pkg::req_item_type item,
   input  logic                  advance,
   input  logic                  absolute_mode,
   output logic                  produce,
   output gwp_pkg::record_type   record
);

   // Tokenizer and number state.
   logic                       in_comment_ff, in_comment_in;
   logic [7:0]                 pending_letter_ff, pending_letter_in;
   logic [gwp_pkg::MANT_W-1:0] mantissa_ff, mantissa_in;
   logic [gwp_pkg::MANT_W-1:0] int_part_ff, int_part_in;
   logic [gwp_pkg::FRAC_W-1:0] fraction_count_ff, fraction_count_in;
   logic                       point_seen_ff, point_seen_in;
   logic                       minus_seen_ff, minus_seen_in;
   logic                       digit_seen_ff, digit_seen_in;
   logic                       number_closed_ff, number_closed_in;
   logic                       mantissa_sat_ff, mantissa_sat_in;

   // Current command state.
   logic [23:0]        cur_line_ff, cur_line_in;
   logic               have_command_ff, have_command_in;
   logic [15:0]        cur_gcode_ff, cur_gcode_in;
   logic signed [31:0] cur_x_ff, cur_x_in;
   logic signed [31:0] cur_y_ff, cur_y_in;
   logic signed [31:0] cur_z_ff, cur_z_in;

   // Evaluation of the pending word.
   logic                        ev_axis;
   logic                        ev_known;
   logic [gwp_pkg::MANT_W-1:0]  int_value;
   logic [23:0]                 n_value;
   logic [15:0]                 g_value;
   logic [gwp_pkg::FRAC_W-1:0]  scale_idx;
   logic [gwp_pkg::PROD_W-1:0]  thou_product;
   logic [gwp_pkg::LIM_W-1:0]   thou_limit;
   logic [gwp_pkg::LIM_W-1:0]   thou_mag;
   logic signed [31:0]          thou_value;
   gwp_pkg::event_kind_type     ev_kind;
   logic [23:0]                 ev_line;
   logic [15:0]                 ev_gcode;
   logic                        ev_have;
   logic signed [31:0]          ev_x, ev_y, ev_z;

   // Character decoding.
   logic [7:0]                  c;
   logic                        comment_next;
   logic                        is_letter;
   logic                        is_digit;
   logic                        raw_produce;
   logic [gwp_pkg::MANT_W+3:0]  next_mant;

   // Integer part for the G and N fields: saturated, and zero for a negative value.
   always_comb begin
      int_value = point_seen_ff ? int_part_ff : mantissa_ff;
      if (minus_seen_ff) begin
         n_value = '0;
         g_value = '0;
      end else begin
         if (mantissa_sat_ff || int_value > {8'd0, gwp_pkg::LINE_MAX}) begin
            n_value = gwp_pkg::LINE_MAX;
         end else begin
            n_value = int_value[23:0];
         end
         if (mantissa_sat_ff || int_value > {16'd0, gwp_pkg::GCODE_MAX}) begin
            g_value = gwp_pkg::GCODE_MAX;
         end else begin
            g_value = int_value[15:0];
         end
      end
   end

   // Axis value in thousandths: one constant-table multiply, then clamp and sign.
   assign scale_idx    = gwp_pkg::FRAC_W'(gwp_pkg::DECIMALS) - fraction_count_ff;
   assign thou_product = gwp_pkg::PROD_W'(mantissa_ff)
                         * gwp_pkg::PROD_W'(gwp_pkg::SCALE_TAB[scale_idx]);
   assign thou_limit   = minus_seen_ff ? gwp_pkg::NEG_LIMIT : gwp_pkg::POS_LIMIT;

   always_comb begin
      if (mantissa_sat_ff || thou_product > gwp_pkg::PROD_W'(thou_limit)) begin
         thou_mag = thou_limit;
      end else begin
         thou_mag = thou_product[gwp_pkg::LIM_W-1:0];
      end
      thou_value = minus_seen_ff ? $signed(32'd0 - thou_mag[31:0]) : $signed(thou_mag[31:0]);
   end

   // Effect of the pending word on the command state.
   always_comb begin
      ev_axis  = (pending_letter_ff == gwp_pkg::CH_X) || (pending_letter_ff == gwp_pkg::CH_Y)
                 || (pending_letter_ff == gwp_pkg::CH_Z);
      ev_known = ev_axis || (pending_letter_ff == gwp_pkg::CH_N)
                 || (pending_letter_ff == gwp_pkg::CH_G);
      ev_kind  = gwp_pkg::EV_UNKNOWN;
      ev_line  = cur_line_ff;
      ev_gcode = cur_gcode_ff;
      ev_have  = have_command_ff;
      ev_x     = cur_x_ff;
      ev_y     = cur_y_ff;
      ev_z     = cur_z_ff;
      if (!ev_known) begin
         ev_kind = gwp_pkg::EV_UNKNOWN;
      end else if (!digit_seen_ff) begin
         ev_kind = gwp_pkg::EV_EMPTY;
      end else if (ev_axis && !have_command_ff) begin
         ev_kind = gwp_pkg::EV_NO_COMMAND;
      end else begin
         case (pending_letter_ff)
            gwp_pkg::CH_N: begin
               ev_kind = gwp_pkg::EV_LINE;
               ev_line = n_value;
            end
            gwp_pkg::CH_G: begin
               ev_kind  = gwp_pkg::EV_COMMAND;
               ev_gcode = g_value;
               ev_have  = 1'b1;
               if (!(absolute_mode && have_command_ff)) begin
                  ev_x = '0;
                  ev_y = '0;
                  ev_z = '0;
               end
            end
            gwp_pkg::CH_X: begin
               ev_kind = gwp_pkg::EV_X;
               ev_x    = thou_value;
            end
            gwp_pkg::CH_Y: begin
               ev_kind = gwp_pkg::EV_Y;
               ev_y    = thou_value;
            end
            gwp_pkg::CH_Z: begin
               ev_kind = gwp_pkg::EV_Z;
               ev_z    = thou_value;
            end
            default: begin
               ev_kind = gwp_pkg::EV_UNKNOWN;
            end
         endcase
      end
   end

   // The record carries the state after the word took effect.
   always_comb begin
      record.event_kind   = ev_kind;
      record.word_letter  = pending_letter_ff;
      record.gcode_number = ev_gcode;
      record.line_number  = ev_line;
      record.x_thou       = ev_x;
      record.y_thou       = ev_y;
      record.z_thou       = ev_z;
   end

   // Next state for the request in the input register.
   always_comb begin
      c            = item.char_code;
      is_letter    = c inside {[gwp_pkg::CH_A:gwp_pkg::CH_Z]};
      is_digit     = c inside {[gwp_pkg::CH_0:gwp_pkg::CH_9]};
      next_mant    = (gwp_pkg::MANT_W+4)'(mantissa_ff) * (gwp_pkg::MANT_W+4)'(10)
                     + (gwp_pkg::MANT_W+4)'(c - gwp_pkg::CH_0);
      comment_next = in_comment_ff;
      if (c == gwp_pkg::CH_LPAREN) begin
         comment_next = 1'b1;
      end else if (c == gwp_pkg::CH_RPAREN) begin
         comment_next = 1'b0;
      end

      raw_produce       = 1'b0;
      in_comment_in     = in_comment_ff;
      pending_letter_in = pending_letter_ff;
      mantissa_in       = mantissa_ff;
      int_part_in       = int_part_ff;
      fraction_count_in = fraction_count_ff;
      point_seen_in     = point_seen_ff;
      minus_seen_in     = minus_seen_ff;
      digit_seen_in     = digit_seen_ff;
      number_closed_in  = number_closed_ff;
      mantissa_sat_in   = mantissa_sat_ff;
      cur_line_in       = cur_line_ff;
      have_command_in   = have_command_ff;
      cur_gcode_in      = cur_gcode_ff;
      cur_x_in          = cur_x_ff;
      cur_y_in          = cur_y_ff;
      cur_z_in          = cur_z_ff;

      if (item.end_of_text || (is_letter && !comment_next)) begin
         // A word boundary: evaluate the pending word, then start a fresh one.
         raw_produce = (pending_letter_ff != gwp_pkg::NO_LETTER);
         if (raw_produce) begin
            cur_line_in     = ev_line;
            have_command_in = ev_have;
            cur_gcode_in    = ev_gcode;
            cur_x_in        = ev_x;
            cur_y_in        = ev_y;
            cur_z_in        = ev_z;
         end
         mantissa_in       = '0;
         int_part_in       = '0;
         fraction_count_in = '0;
         point_seen_in     = 1'b0;
         minus_seen_in     = 1'b0;
         digit_seen_in     = 1'b0;
         number_closed_in  = 1'b0;
         mantissa_sat_in   = 1'b0;
         if (item.end_of_text) begin
            pending_letter_in = gwp_pkg::NO_LETTER;
            in_comment_in     = 1'b0;
         end else begin
            pending_letter_in = c;
            in_comment_in     = comment_next;
         end
      end else begin
         in_comment_in = comment_next;
         if (!comment_next && c != gwp_pkg::CH_SPACE && c != gwp_pkg::CH_LF
             && pending_letter_ff != gwp_pkg::NO_LETTER && !number_closed_ff) begin
            // Number characters of the open word.
            if (c == gwp_pkg::CH_MINUS) begin
               if (digit_seen_ff || point_seen_ff || minus_seen_ff) begin
                  number_closed_in = 1'b1;
               end else begin
                  minus_seen_in = 1'b1;
               end
            end else if (c == gwp_pkg::CH_POINT) begin
               if (point_seen_ff) begin
                  number_closed_in = 1'b1;
               end else begin
                  point_seen_in = 1'b1;
                  int_part_in   = mantissa_ff;
               end
            end else if (is_digit) begin
               digit_seen_in = 1'b1;
               if ((point_seen_ff && fraction_count_ff >= gwp_pkg::FRAC_W'(gwp_pkg::DECIMALS))
                   || mantissa_sat_ff) begin
                  // Truncated fraction digit or saturated mantissa: digit is dropped.
                  mantissa_in = mantissa_ff;
               end else if (next_mant > (gwp_pkg::MANT_W+4)'(gwp_pkg::MANT_MAX)) begin
                  mantissa_sat_in = 1'b1;
               end else begin
                  mantissa_in = next_mant[gwp_pkg::MANT_W-1:0];
                  if (point_seen_ff) begin
                     fraction_count_in = fraction_count_ff + gwp_pkg::FRAC_W'(1);
                  end
               end
            end
         end
      end
   end

   assign produce = item_valid && raw_produce;

   // State registers move only when the core takes the held request.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_comment_ff     <= 1'b0;
         pending_letter_ff <= gwp_pkg::NO_LETTER;
         mantissa_ff       <= '0;
         int_part_ff       <= '0;
         fraction_count_ff <= '0;
         point_seen_ff     <= 1'b0;
         minus_seen_ff     <= 1'b0;
         digit_seen_ff     <= 1'b0;
         number_closed_ff  <= 1'b0;
         mantissa_sat_ff   <= 1'b0;
         cur_line_ff       <= '0;
         have_command_ff   <= 1'b0;
         cur_gcode_ff      <= '0;
         cur_x_ff          <= '0;
         cur_y_ff          <= '0;
         cur_z_ff          <= '0;
      end else if (advance) begin
         in_comment_ff     <= in_comment_in;
         pending_letter_ff <= pending_letter_in;
         mantissa_ff       <= mantissa_in;
         int_part_ff       <= int_part_in;
         fraction_count_ff <= fraction_count_in;
         point_seen_ff     <= point_seen_in;
         minus_seen_ff     <= minus_seen_in;
         digit_seen_ff     <= digit_seen_in;
         number_closed_ff  <= number_closed_in;
         mantissa_sat_ff   <= mantissa_sat_in;
         cur_line_ff       <= cur_line_in;
         have_command_ff   <= have_command_in;
         cur_gcode_ff      <= cur_gcode_in;
         cur_x_ff          <= cur_x_in;
         cur_y_ff          <= cur_y_in;
         cur_z_ff          <= cur_z_in;
      end
   end

endmodule

>>> rtl/core/gwp_rsp_stage.sv
// Result register of the G-code word parser, holding one record until the receiver takes it.
`timescale 1ns / 1ps

module gwp_rsp_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  gwp_pkg::pipe_ctrl_type ctrl,
   input  gwp_pkg::record_type    record,
   output logic                   can_take,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output gwp_pkg::record_type    rsp_record
);

   logic                valid_ff;
   logic                valid_in;
   logic                load;
   gwp_pkg::record_type record_ff;

   // A new record may enter when the register is empty or is being drained.
   assign can_take = !valid_ff || !rsp_stall;
   assign load     = ctrl.produce && ctrl.advance;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Record payload capture.
   always_ff @(posedge clock) begin
      if (load) begin
         record_ff <= record;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_record = record_ff;

endmodule
